// File: src/tss_pkg.sv
// Shared types and constants for the TDMA slot scheduler.
// No dependencies; imported by every module of the block.
package tss_pkg;

  localparam int unsigned CLIENT_W = 6;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned FRAME_W  = 32;
  localparam int unsigned ACTIVE_W = 7;
  localparam int unsigned WAIT_W   = 22;
  localparam int unsigned MAP_W    = 64;

  localparam logic [TICK_W-1:0] SLOT_TICKS_RST = 16'd100;
  localparam logic [WAIT_W-1:0] WAIT_MAX       = 22'h3FFFFF;

  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_CONNECT    = 2'd1,
    KIND_DISCONNECT = 2'd2,
    KIND_TRANSMIT   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_COLLISION = 2'd2,
    ST_INACTIVE  = 2'd3
  } status_t;

  typedef struct packed {
    kind_t               kind;
    logic [CLIENT_W-1:0] client;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [CLIENT_W-1:0] assigned_client;
    logic [CLIENT_W-1:0] slot_index;
    logic [FRAME_W-1:0]  frame_total;
    logic [ACTIVE_W-1:0] slot_count;
    logic                owner_valid;
    logic [CLIENT_W-1:0] owner_client;
    logic                slot_changed;
    logic [WAIT_W-1:0]   wait_ticks;
  } result_t;

  // Scheduler view handed to the wait calculator
  typedef struct packed {
    logic                active;
    logic [CLIENT_W-1:0] client;
    logic [CLIENT_W-1:0] slot;
    logic [TICK_W-1:0]   tick;
    logic [TICK_W-1:0]   slot_ticks;
    logic [ACTIVE_W-1:0] act;
  } wait_req_t;

endpackage

// File: src/tdma_slot_scheduler_unit.sv
// Top level of the TDMA slot scheduler: input register, scheduler core,
// result register. Depends on tss_pkg and tss_core.
//
//   channel   ports                     transfer
//   command   start, busy, cmd          start high while busy low
//   config    cfg_we, cfg_data          cfg_we high
//   result    done, result              done high for one cycle
//
// One command is taken every cycle; busy stays low.
// A result passes the input register, then the core update and wait
// multiply into the result register.
// Reset (rst, synchronous) empties the client table, zeroes slot, tick and
// frame counters and sets slot_ticks to 100.
// Results are not held; the receiver takes each one in its done cycle.
module tdma_slot_scheduler_unit
  import tss_pkg::*;
#(
  parameter int unsigned NUM_CLIENTS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_data,
  output logic              done,
  output result_t           result
);

  logic    cmd_vld;
  cmd_t    cmd_q;
  result_t core_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      cmd_vld <= start;
      done    <= cmd_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q <= cmd;
    end
    if (cmd_vld) begin
      result <= core_res;
    end
  end

  tss_core #(
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item_vld (cmd_vld),
    .item     (cmd_q),
    .res      (core_res)
  );

endmodule

// File: src/tss_wait.sv
// Wait-until-slot calculator: one 7x16 multiply, add and saturate.
// Depends on tss_pkg.
module tss_wait
  import tss_pkg::*;
(
  input  wait_req_t         req,
  output logic [WAIT_W-1:0] wait_ticks
);

  logic [ACTIVE_W-1:0]        mult;
  logic                       add_one;
  logic [ACTIVE_W+TICK_W-1:0] prod;
  logic [ACTIVE_W+TICK_W:0]   total;
  logic [TICK_W-1:0]          own_left;

  always_comb begin
    mult    = '0;
    add_one = 1'b0;
    if ({1'b0, req.slot} >= req.act) begin
      // frame restart pending: one tick to restart, then whole slots
      mult    = ACTIVE_W'(req.client);
      add_one = 1'b1;
    end else if (req.client > req.slot) begin
      mult = ACTIVE_W'(req.client - req.slot);
    end else begin
      mult = req.act - ACTIVE_W'(req.slot) + ACTIVE_W'(req.client);
    end
  end

  assign prod     = mult * req.slot_ticks;
  assign total    = (ACTIVE_W+TICK_W+1)'(prod) + (ACTIVE_W+TICK_W+1)'(add_one);
  assign own_left = (req.tick < req.slot_ticks) ? req.slot_ticks - req.tick
                                                : TICK_W'(1);

  always_comb begin
    if (!req.active) begin
      wait_ticks = '0;
    end else if (req.client == req.slot) begin
      wait_ticks = WAIT_W'(own_left);
    end else if (total > (ACTIVE_W+TICK_W+1)'(WAIT_MAX)) begin
      wait_ticks = WAIT_MAX;
    end else begin
      wait_ticks = WAIT_W'(total);
    end
  end

endmodule

// File: src/tss_core.sv
// Scheduler state and its per-item update: slot timing, client table,
// status and the result fields. Depends on tss_pkg and tss_wait.
module tss_core
  import tss_pkg::*;
#(
  parameter int unsigned NUM_CLIENTS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_data,
  input  logic              item_vld,
  input  cmd_t              item,
  output result_t           res
);

  localparam int unsigned CNT_W = $clog2(NUM_CLIENTS + 1);

  logic [TICK_W-1:0]      slot_ticks;
  logic [NUM_CLIENTS-1:0] active_map, active_map_next;
  logic [CNT_W-1:0]       active_count, active_count_next;
  logic [TICK_W-1:0]      tick_in_slot, tick_in_slot_next;
  logic [CLIENT_W-1:0]    slot_now, slot_now_next;
  logic [FRAME_W-1:0]     frames, frames_next;

  logic [TICK_W-1:0]   eff_ticks;
  logic [ACTIVE_W-1:0] eff_act, eff_act_next;
  logic [MAP_W-1:0]    map_ext, map_ext_next;
  logic [TICK_W-1:0]   tick_inc, tick_mid;
  logic [CLIENT_W-1:0] slot_mid;
  logic                slot_end;
  logic                free_found;
  logic [CLIENT_W-1:0] free_idx;
  logic                named_ok;
  logic [CLIENT_W-1:0] named;
  status_t             status;
  logic [CLIENT_W-1:0] assigned;
  wait_req_t           wreq;
  logic [WAIT_W-1:0]   wait_ticks;

  assign eff_ticks = (slot_ticks == '0) ? TICK_W'(1) : slot_ticks;
  assign eff_act   = (active_count == '0) ? ACTIVE_W'(1) : ACTIVE_W'(active_count);
  assign map_ext   = MAP_W'(active_map);

  // lowest free entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_CLIENTS - 1; i >= 0; i--) begin
      if (!active_map[i]) begin
        free_found = 1'b1;
        free_idx   = CLIENT_W'(i);
      end
    end
  end

  assign tick_inc = tick_in_slot + TICK_W'(1);
  assign slot_end = (tick_inc == '0) || (tick_inc >= eff_ticks);
  assign slot_mid = slot_end ? slot_now + CLIENT_W'(1) : slot_now;
  assign tick_mid = slot_end ? '0 : tick_inc;

  always_comb begin
    active_map_next   = active_map;
    active_count_next = active_count;
    tick_in_slot_next = tick_in_slot;
    slot_now_next     = slot_now;
    frames_next       = frames;
    status            = ST_OK;
    assigned          = '0;
    named_ok          = 1'b1;
    named             = item.client;
    unique case (item.kind)
      KIND_TICK: begin
        tick_in_slot_next = tick_mid;
        slot_now_next     = slot_mid;
        if ({1'b0, slot_mid} >= eff_act) begin
          // start a new frame
          slot_now_next     = '0;
          tick_in_slot_next = '0;
          frames_next       = frames + FRAME_W'(1);
        end
      end
      KIND_CONNECT: begin
        if (free_found) begin
          active_map_next   = active_map | (NUM_CLIENTS'(1) << free_idx);
          active_count_next = active_count + CNT_W'(1);
          assigned          = free_idx;
          named             = free_idx;
        end else begin
          status   = ST_FULL;
          named_ok = 1'b0;
        end
      end
      KIND_DISCONNECT: begin
        if (map_ext[item.client]) begin
          active_map_next   = active_map & ~(NUM_CLIENTS'(1) << item.client);
          active_count_next = active_count - CNT_W'(1);
        end else begin
          status = ST_INACTIVE;
        end
      end
      KIND_TRANSMIT: begin
        if (!map_ext[item.client]) begin
          status = ST_INACTIVE;
        end else if (item.client != slot_now) begin
          status = ST_COLLISION;
        end
      end
      default: ;
    endcase
  end

  assign eff_act_next = (active_count_next == '0) ? ACTIVE_W'(1)
                                                  : ACTIVE_W'(active_count_next);
  assign map_ext_next = MAP_W'(active_map_next);

  assign wreq.active     = named_ok && map_ext_next[named];
  assign wreq.client     = named;
  assign wreq.slot       = slot_now_next;
  assign wreq.tick       = tick_in_slot_next;
  assign wreq.slot_ticks = eff_ticks;
  assign wreq.act        = eff_act_next;

  tss_wait u_wait (
    .req        (wreq),
    .wait_ticks (wait_ticks)
  );

  always_comb begin
    res.status          = status;
    res.assigned_client = assigned;
    res.slot_index      = slot_now_next;
    res.frame_total     = frames_next;
    res.slot_count      = eff_act_next;
    res.owner_valid     = map_ext_next[slot_now_next];
    res.owner_client    = map_ext_next[slot_now_next] ? slot_now_next : '0;
    res.slot_changed    = (item.kind == KIND_TICK) && (slot_now_next != slot_now);
    res.wait_ticks      = wait_ticks;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks   <= SLOT_TICKS_RST;
      active_map   <= '0;
      active_count <= '0;
      tick_in_slot <= '0;
      slot_now     <= '0;
      frames       <= '0;
    end else begin
      if (cfg_we) begin
        slot_ticks <= cfg_data;
      end
      if (item_vld) begin
        active_map   <= active_map_next;
        active_count <= active_count_next;
        tick_in_slot <= tick_in_slot_next;
        slot_now     <= slot_now_next;
        frames       <= frames_next;
      end
    end
  end

endmodule
